/* hw/rtl/cfar_threshold_detector_assert.svh */
// Assertion macros shared by the CFAR detector RTL.
// Included by the top level; needs nothing else.
`ifndef CFAR_THRESHOLD_DETECTOR_ASSERT_SVH
`define CFAR_THRESHOLD_DETECTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFAR_ASSERT_SAME(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cfar detector: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CFAR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cfar detector: next-cycle check failed");

`endif

/* hw/rtl/cfar_pkg.sv */
// Package for the CFAR threshold detector: sizes, codes and shared types.
// Used by every module of the block; depends on nothing.
package cfar_pkg;

  // Window geometry.
  localparam int REF_BITS   = 4;
  localparam int GUARD      = 2;
  localparam int EDGE_SKIP  = 18;
  localparam int ALPHA_FRAC = 8;
  localparam int REF        = 1 << REF_BITS;
  localparam int CUT        = REF + GUARD;
  localparam int WIN        = 2 * REF + 2 * GUARD + 1;

  // Field and datapath widths.
  localparam int DATA_W    = 32;
  localparam int SUM_W     = 36;
  localparam int NOISE_W   = SUM_W + 1;
  localparam int ALPHA_W   = 16;
  localparam int PROD_W    = NOISE_W + ALPHA_W;
  localparam int LEN_W     = 16;
  localparam int ITER_W    = LEN_W + 1;
  localparam int DRAIN_W   = $clog2(CUT);
  localparam int THR_SHIFT = REF_BITS + ALPHA_FRAC;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ALPHA_GAIN   = 2'd0,
    CFG_DETECT_MODE  = 2'd1,
    CFG_SWEEP_LENGTH = 2'd2
  } cfg_idx_e;

  // Noise estimate selection.
  typedef enum logic [1:0] {
    MODE_CA     = 2'd0,
    MODE_GO     = 2'd1,
    MODE_SO     = 2'd2,
    MODE_CA_ALT = 2'd3
  } detect_mode_e;

  // Sweep sequencer states.
  typedef enum logic {
    ST_RUN   = 1'b0,
    ST_DRAIN = 1'b1
  } ctl_state_e;

  // Per-result flags decided when the window shifts.
  typedef struct packed {
    logic edge_ok;
    logic last;
  } cut_info_t;

endpackage

/* hw/rtl/cfar_cell.sv */
// One 32-bit window cell of the CFAR sliding window.
// Depends on cfar_pkg for the word width.
module cfar_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       clr_i,
  input  logic [cfar_pkg::DATA_W-1:0] d_i,
  output logic [cfar_pkg::DATA_W-1:0] q_o
);
  import cfar_pkg::*;

  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] val_d;

  // Take the neighbor's word on a shift, or zero when the flush ends.
  always_comb begin
    val_d = val_q;
    if (adv_i) begin
      val_d = clr_i ? '0 : d_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  assign q_o = val_q;

endmodule

/* hw/rtl/cfar_window.sv */
// Sliding window built from a row of cfar_cell, plus the running sums of the
// lagging and leading reference cells. Depends on cfar_pkg and cfar_cell.
module cfar_window (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       clr_i,
  input  logic [cfar_pkg::DATA_W-1:0] sample_i,
  output logic [cfar_pkg::DATA_W-1:0] cut_o,
  output logic [cfar_pkg::SUM_W-1:0]  lag_o,
  output logic [cfar_pkg::SUM_W-1:0]  lead_o
);
  import cfar_pkg::*;

  logic [DATA_W-1:0] cell_q [WIN];
  logic [SUM_W-1:0]  lag_q;
  logic [SUM_W-1:0]  lead_q;
  logic [SUM_W-1:0]  lag_d;
  logic [SUM_W-1:0]  lead_d;

  // The row of cells; each one passes its word to the next on a shift.
  for (genvar j = 0; j < WIN; j++) begin : g_cell
    if (j == 0) begin : g_head
      cfar_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .adv_i  (adv_i),
        .clr_i  (clr_i),
        .d_i    (sample_i),
        .q_o    (cell_q[j])
      );
    end else begin : g_body
      cfar_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .adv_i  (adv_i),
        .clr_i  (clr_i),
        .d_i    (cell_q[j-1]),
        .q_o    (cell_q[j])
      );
    end
  end

  // Running sums after this shift; they wrap at the sum width.
  assign lag_d  = lag_q + SUM_W'(sample_i) - SUM_W'(cell_q[REF-1]);
  assign lead_d = lead_q + SUM_W'(cell_q[REF+2*GUARD]) - SUM_W'(cell_q[WIN-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lag_q  <= '0;
      lead_q <= '0;
    end else if (adv_i) begin
      lag_q  <= clr_i ? '0 : lag_d;
      lead_q <= clr_i ? '0 : lead_d;
    end
  end

  // The word that lands in the test position on this shift.
  assign cut_o  = cell_q[CUT-1];
  assign lag_o  = lag_d;
  assign lead_o = lead_d;

endmodule

/* hw/rtl/cfar_thresh.sv */
// Elastic threshold pipeline: noise selection, gain multiply, compare and the
// output register. Depends on cfar_pkg.
module cfar_thresh (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic [cfar_pkg::DATA_W-1:0]        cut_i,
  input  logic [cfar_pkg::SUM_W-1:0]         lag_i,
  input  logic [cfar_pkg::SUM_W-1:0]         lead_i,
  input  cfar_pkg::cut_info_t                info_i,
  input  cfar_pkg::detect_mode_e             mode_i,
  input  logic [cfar_pkg::ALPHA_W-1:0]       alpha_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [cfar_pkg::DATA_W-1:0]        test_power_o,
  output logic                              detect_flag_o,
  output logic                              sweep_last_o
);
  import cfar_pkg::*;

  // Stage 1: captured window outputs.
  logic              v1_q;
  logic [DATA_W-1:0] cut1_q;
  logic [SUM_W-1:0]  lag1_q;
  logic [SUM_W-1:0]  lead1_q;
  cut_info_t         info1_q;
  // Stage 2: selected noise sum.
  logic              v2_q;
  logic [DATA_W-1:0] cut2_q;
  logic [NOISE_W-1:0] noise2_q;
  logic              ca2_q;
  cut_info_t         info2_q;
  // Stage 3: scaled noise.
  logic              v3_q;
  logic [DATA_W-1:0] cut3_q;
  logic [PROD_W-1:0] prod3_q;
  logic              ca3_q;
  cut_info_t         info3_q;
  // Output register.
  logic              ov_q;
  logic [DATA_W-1:0] opow_q;
  logic              odet_q;
  logic              olast_q;

  logic               r1;
  logic               r2;
  logic               r3;
  logic               ro;
  logic [NOISE_W-1:0] noise_d;
  logic               ca_d;
  logic [PROD_W-1:0]  prod_d;
  logic [PROD_W-1:0]  thr;
  logic               det_d;

  // A stage moves on when it is empty or its successor moves on.
  assign ro = !ov_q || !out_stall_i;
  assign r3 = !v3_q || ro;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign ready_o = r1;

  // Noise estimate: both sides, the greater side or the smaller side.
  always_comb begin
    noise_d = NOISE_W'(lag1_q) + NOISE_W'(lead1_q);
    ca_d    = 1'b1;
    unique case (mode_i)
      MODE_GO: begin
        noise_d = NOISE_W'((lead1_q > lag1_q) ? lead1_q : lag1_q);
        ca_d    = 1'b0;
      end
      MODE_SO: begin
        noise_d = NOISE_W'((lead1_q < lag1_q) ? lead1_q : lag1_q);
        ca_d    = 1'b0;
      end
      MODE_CA, MODE_CA_ALT: begin
        noise_d = NOISE_W'(lag1_q) + NOISE_W'(lead1_q);
        ca_d    = 1'b1;
      end
    endcase
  end

  assign prod_d = PROD_W'(noise2_q) * PROD_W'(alpha_i);

  // Threshold shift covers the averaging over one or both sides.
  assign thr   = ca3_q ? (prod3_q >> (THR_SHIFT + 1)) : (prod3_q >> THR_SHIFT);
  assign det_d = info3_q.edge_ok && (PROD_W'(cut3_q) > thr);

  // Valid bits of the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (r1) begin
        v1_q <= valid_i;
      end
      if (r2) begin
        v2_q <= v1_q;
      end
      if (r3) begin
        v3_q <= v2_q;
      end
      if (ro) begin
        ov_q <= v3_q;
      end
    end
  end

  // Payload of the stages, loaded only with a valid word.
  always_ff @(posedge clk_i) begin
    if (r1 && valid_i) begin
      cut1_q  <= cut_i;
      lag1_q  <= lag_i;
      lead1_q <= lead_i;
      info1_q <= info_i;
    end
    if (r2 && v1_q) begin
      cut2_q   <= cut1_q;
      noise2_q <= noise_d;
      ca2_q    <= ca_d;
      info2_q  <= info1_q;
    end
    if (r3 && v2_q) begin
      cut3_q  <= cut2_q;
      prod3_q <= prod_d;
      ca3_q   <= ca2_q;
      info3_q <= info2_q;
    end
    if (ro && v3_q) begin
      opow_q  <= cut3_q;
      odet_q  <= det_d;
      olast_q <= info3_q.last;
    end
  end

  assign out_valid_o   = ov_q;
  assign test_power_o  = opow_q;
  assign detect_flag_o = odet_q;
  assign sweep_last_o  = olast_q;

endmodule

/* hw/rtl/cfar_threshold_detector.sv */
// CFAR threshold detector, top level: configuration registers, sweep
// sequencer, window row and threshold pipeline.
// Depends on cfar_pkg, cfar_window, cfar_thresh and the assertion header.
//
// Usage: power samples enter on the input channel (in_valid_i, in_stall_o,
// power_sample_i); results leave on the output channel (out_valid_o,
// out_stall_i, test_power_o, detect_flag_o, sweep_last_o). A word moves when
// valid is high and stall is low. Registers are written through cfg_we_i,
// cfg_index_i and cfg_wdata_i while the block is idle.
// Each accepted sample shifts the 37-cell window; its result passes through
// stage 1, stage 2, stage 3 and the output register, where it can be taken.
// One sample is taken per cycle while the input is not stalled. The first 18
// samples of a sweep give no result. After the last sample of a sweep the
// window is flushed with 18 zeros, one result each, during which the input
// is stalled; the window and sums are then cleared. When the receiver stalls,
// the output word holds and the four-stage pipeline fills its empty slots
// before the input stalls.
// Reset clears the window, sums and sample count and loads alpha_gain 256,
// cell-averaging mode and a sweep length of 1024.
`include "cfar_threshold_detector_assert.svh"

module cfar_threshold_detector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cfar_pkg::DATA_W-1:0]    power_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cfar_pkg::DATA_W-1:0]    test_power_o,
  output logic                          detect_flag_o,
  output logic                          sweep_last_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [cfar_pkg::ALPHA_W-1:0]   cfg_wdata_i
);
  import cfar_pkg::*;

  logic [ALPHA_W-1:0] alpha_q;
  detect_mode_e       mode_q;
  logic [LEN_W-1:0]   sweep_length_q;

  ctl_state_e         st_q;
  ctl_state_e         st_d;
  logic [ITER_W-1:0]  iter_q;
  logic [DRAIN_W-1:0] drain_cnt_q;

  logic               rdy1;
  logic               exec;
  logic               src_zero;
  logic               end_hit;
  logic               drain_last;
  logic               clr;
  logic               emit;
  logic               in_drain;
  logic               sweep_end;
  logic [LEN_W-1:0]   next_cnt;
  logic [ITER_W-1:0]  cell_idx;
  logic [ITER_W-1:0]  len_eff;
  logic [DATA_W-1:0]  sample;
  logic [DATA_W-1:0]  win_cut;
  logic [SUM_W-1:0]   win_lag;
  logic [SUM_W-1:0]   win_lead;
  cut_info_t          info;

  // Configuration registers; an unknown index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q        <= ALPHA_W'(256);
      mode_q         <= MODE_CA;
      sweep_length_q <= LEN_W'(1024);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ALPHA_GAIN:   alpha_q        <= cfg_wdata_i;
        CFG_DETECT_MODE:  mode_q         <= detect_mode_e'(cfg_wdata_i[1:0]);
        CFG_SWEEP_LENGTH: sweep_length_q <= cfg_wdata_i;
        default:          ;
      endcase
    end
  end

  // Sweep bookkeeping: end of sweep and the end of the flush.
  assign next_cnt   = iter_q[LEN_W-1:0] + LEN_W'(1);
  assign end_hit    = (next_cnt == sweep_length_q);
  assign drain_last = (drain_cnt_q == DRAIN_W'(CUT - 1));
  assign in_drain   = (st_q == ST_DRAIN);
  assign sweep_end  = exec && !in_drain && end_hit;

  // Next state of the sequencer.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_RUN: begin
        if (exec && end_hit) begin
          st_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (exec && drain_last) begin
          st_d = ST_RUN;
        end
      end
    endcase
  end

  // Sequencer outputs: input handshake, zero fill and shift enable.
  always_comb begin
    in_stall_o = 1'b1;
    src_zero   = 1'b0;
    exec       = 1'b0;
    unique case (st_q)
      ST_RUN: begin
        in_stall_o = !rdy1;
        exec       = in_valid_i && rdy1;
      end
      ST_DRAIN: begin
        src_zero = 1'b1;
        exec     = rdy1;
      end
    endcase
  end

  assign clr    = exec && (st_q == ST_DRAIN) && drain_last;
  assign sample = src_zero ? '0 : power_sample_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_RUN;
      iter_q      <= '0;
      drain_cnt_q <= '0;
    end else begin
      st_q <= st_d;
      if (exec) begin
        priority if (st_q == ST_DRAIN && drain_last) begin
          iter_q      <= '0;
          drain_cnt_q <= '0;
        end else if (st_q == ST_DRAIN) begin
          iter_q      <= iter_q + ITER_W'(1);
          drain_cnt_q <= drain_cnt_q + DRAIN_W'(1);
        end else if (end_hit) begin
          iter_q      <= iter_q + ITER_W'(1);
          drain_cnt_q <= '0;
        end else begin
          iter_q <= {1'b0, next_cnt};
        end
      end
    end
  end

  // Cell index of this shift and its edge and last-cell flags.
  assign emit         = (iter_q >= ITER_W'(CUT));
  assign cell_idx     = iter_q - ITER_W'(CUT);
  assign len_eff      = {(sweep_length_q == '0), sweep_length_q};
  assign info.edge_ok = (cell_idx >= ITER_W'(EDGE_SKIP))
                     && (len_eff > ITER_W'(EDGE_SKIP))
                     && (cell_idx < len_eff - ITER_W'(EDGE_SKIP));
  assign info.last    = (cell_idx == len_eff - ITER_W'(1));

  cfar_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (exec),
    .clr_i    (clr),
    .sample_i (sample),
    .cut_o    (win_cut),
    .lag_o    (win_lag),
    .lead_o   (win_lead)
  );

  cfar_thresh u_thresh (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (exec && emit),
    .ready_o       (rdy1),
    .cut_i         (win_cut),
    .lag_i         (win_lag),
    .lead_i        (win_lead),
    .info_i        (info),
    .mode_i        (mode_q),
    .alpha_i       (alpha_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .test_power_o  (test_power_o),
    .detect_flag_o (detect_flag_o),
    .sweep_last_o  (sweep_last_o)
  );

  // The last sample of a sweep starts a flush from its first slot.
  `CFAR_ASSERT_NEXT(a_drain_entry, clk_i, rst_ni, sweep_end, in_drain && (drain_cnt_q == '0))
  // The end of the flush restarts the sweep count.
  `CFAR_ASSERT_NEXT(a_sweep_restart, clk_i, rst_ni, clr, !in_drain && (iter_q == '0))
  // No sample is taken while the window is flushed.
  `CFAR_ASSERT_SAME(a_no_take_in_drain, clk_i, rst_ni, in_drain, in_stall_o)

endmodule
